FILE: design/calendar_days_between_dates_core_macros.svh
// ----------------------------------------------------------------------------
// calendar days between dates core - assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef CALENDAR_DAYS_BETWEEN_DATES_CORE_MACROS_SVH
`define CALENDAR_DAYS_BETWEEN_DATES_CORE_MACROS_SVH

// same-cycle implication
`define CDBD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cdbd assertion failed");

// next-cycle implication
`define CDBD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cdbd assertion failed");

`endif

FILE: design/cdbd_pkg.sv
// ----------------------------------------------------------------------------
// cdbd_pkg
// constants, types and calendar tables for the days-between-dates core
// ----------------------------------------------------------------------------
package cdbd_pkg;

  localparam logic [13:0] YEAR_MIN     = 14'd1970;
  localparam logic [13:0] YEAR_MAX     = 14'd9999;
  localparam logic [12:0] RECIP_100    = 13'd5243;
  localparam int          RECIP_SHIFT  = 19;
  localparam logic [17:0] DAYS_PER_ERA = 18'd146097;
  localparam logic [22:0] EPOCH_OFFSET = 23'd719468;

  localparam logic [1:0] CLASS_ACTIVE  = 2'd0;
  localparam logic [1:0] CLASS_DUE     = 2'd1;
  localparam logic [1:0] CLASS_EXPIRED = 2'd2;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } cdbd_en_t;

  typedef struct packed {
    logic        ok;
    logic [22:0] num;
  } cdbd_day_t;

  // days in month, february as a common year
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd1:    len = 5'd31;
      4'd2:    len = 5'd28;
      4'd3:    len = 5'd31;
      4'd4:    len = 5'd30;
      4'd5:    len = 5'd31;
      4'd6:    len = 5'd30;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd31;
      4'd9:    len = 5'd30;
      4'd10:   len = 5'd31;
      4'd11:   len = 5'd30;
      4'd12:   len = 5'd31;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  // days before month start, year starting in march
  function automatic logic [8:0] march_doy(input logic [3:0] mp);
    logic [8:0] doy;
    case (mp)
      4'd0:    doy = 9'd0;
      4'd1:    doy = 9'd31;
      4'd2:    doy = 9'd61;
      4'd3:    doy = 9'd92;
      4'd4:    doy = 9'd122;
      4'd5:    doy = 9'd153;
      4'd6:    doy = 9'd184;
      4'd7:    doy = 9'd214;
      4'd8:    doy = 9'd245;
      4'd9:    doy = 9'd275;
      4'd10:   doy = 9'd306;
      4'd11:   doy = 9'd337;
      default: doy = 9'd0;
    endcase
    return doy;
  endfunction

endpackage

FILE: design/cdbd_day_number.sv
// ----------------------------------------------------------------------------
// cdbd_day_number
// four-stage pipeline: date check and day number counted from 1970-01-01
// ----------------------------------------------------------------------------
module cdbd_day_number (
  input  logic               clk,
  input  cdbd_pkg::cdbd_en_t en,
  input  logic [13:0]        year,
  input  logic [3:0]         month,
  input  logic [4:0]         day,
  output cdbd_pkg::cdbd_day_t result
);
  import cdbd_pkg::*;

  // stage 1: shift year to march start, divide by 100
  logic [13:0] yy;
  logic [3:0]  mp;
  logic [26:0] prod_yy;
  logic [26:0] prod_y;
  logic        range_ok;

  assign yy       = (month <= 4'd2) ? year - 14'd1 : year;
  assign mp       = (month > 4'd2) ? month - 4'd3 : month + 4'd9;
  assign prod_yy  = 27'(yy) * 27'(RECIP_100);
  assign prod_y   = 27'(year) * 27'(RECIP_100);
  assign range_ok = (year >= YEAR_MIN) && (year <= YEAR_MAX) &&
                    (month >= 4'd1) && (month <= 4'd12) && (day != 5'd0);

  logic [13:0] a_year;
  logic [7:0]  a_q100y;
  logic [13:0] a_yy;
  logic [7:0]  a_q100yy;
  logic [8:0]  a_doy;
  logic        a_feb;
  logic [4:0]  a_len;
  logic [4:0]  a_day;
  logic        a_range_ok;

  always_ff @(posedge clk) begin
    if (en.s1) begin
      a_year     <= year;
      a_q100y    <= prod_y[RECIP_SHIFT +: 8];
      a_yy       <= yy;
      a_q100yy   <= prod_yy[RECIP_SHIFT +: 8];
      a_doy      <= march_doy(mp) + 9'(day) - 9'd1;
      a_feb      <= (month == 4'd2);
      a_len      <= month_len(month);
      a_day      <= day;
      a_range_ok <= range_ok;
    end
  end

  // stage 2: leap year, day range, era and year of era
  logic       rem_zero;
  logic       leap;
  logic [4:0] len_b;
  logic [5:0] era_b;
  logic [8:0] yoe_b;

  assign rem_zero = (a_year == 14'(a_q100y) * 14'd100);
  assign leap     = ((a_year[1:0] == 2'd0) && !rem_zero) ||
                    (rem_zero && (a_q100y[1:0] == 2'd0));
  assign len_b    = (a_feb && leap) ? 5'd29 : a_len;
  assign era_b    = a_q100yy[7:2];
  assign yoe_b    = 9'(a_yy - 14'(era_b) * 14'd400);

  logic       b_ok;
  logic [5:0] b_era;
  logic [8:0] b_yoe;
  logic [1:0] b_cent;
  logic [8:0] b_doy;

  always_ff @(posedge clk) begin
    if (en.s2) begin
      b_ok   <= a_range_ok && (a_day <= len_b);
      b_era  <= era_b;
      b_yoe  <= yoe_b;
      b_cent <= a_q100yy[1:0];
      b_doy  <= a_doy;
    end
  end

  // stage 3: day of era and era base
  logic        c_ok;
  logic [17:0] c_doe;
  logic [22:0] c_era_days;

  always_ff @(posedge clk) begin
    if (en.s3) begin
      c_ok       <= b_ok;
      c_doe      <= 18'(b_yoe) * 18'd365 + 18'(b_yoe[8:2]) + 18'(b_doy) - 18'(b_cent);
      c_era_days <= 23'(b_era) * 23'(DAYS_PER_ERA);
    end
  end

  // stage 4: day number from epoch
  always_ff @(posedge clk) begin
    if (en.s4) begin
      result.ok  <= c_ok;
      result.num <= c_era_days + 23'(c_doe) - EPOCH_OFFSET;
    end
  end

endmodule

FILE: design/calendar_days_between_dates_core.sv
// ----------------------------------------------------------------------------
// calendar_days_between_dates_core
// Takes one current/target date pair per cycle and returns target minus
// current in days, a both-dates-valid flag and a countdown class. An item
// transfers in, passes an input register, four day-number stages and a
// difference stage, and appears on the result register. Five register stages
// lie behind the input register, and throughput is one pair per cycle
// while the result side keeps up. Stalled stages hold their data and empty
// stages fill, so the input stalls only when the pipeline is full and the
// result side stalls. Invalid dates (year outside 1970..9999, bad month or
// day) give zero days, flag low and class due today. No memories, no
// clearing pass after reset.
// ----------------------------------------------------------------------------
`include "calendar_days_between_dates_core_macros.svh"

module calendar_days_between_dates_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               date_valid,
  output logic               date_stall,
  input  logic [13:0]        current_year,
  input  logic [3:0]         current_month,
  input  logic [4:0]         current_day,
  input  logic [13:0]        target_year,
  input  logic [3:0]         target_month,
  input  logic [4:0]         target_day,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [22:0] days_between,
  output logic               dates_valid,
  output logic [1:0]         countdown_class
);
  import cdbd_pkg::*;

  logic [5:0] vld;
  logic [5:0] adv;

  // a stage moves when it is empty or its successor moves
  always_comb begin
    adv[5] = !vld[5] || !result_stall;
    for (int i = 4; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign date_stall   = !adv[0];
  assign result_valid = vld[5];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= date_valid;
      end
      for (int i = 1; i < 6; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // input register
  logic [13:0] cy;
  logic [3:0]  cm;
  logic [4:0]  cd;
  logic [13:0] ty;
  logic [3:0]  tm;
  logic [4:0]  td;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      cy <= current_year;
      cm <= current_month;
      cd <= current_day;
      ty <= target_year;
      tm <= target_month;
      td <= target_day;
    end
  end

  cdbd_en_t  en;
  cdbd_day_t cur;
  cdbd_day_t tgt;

  assign en.s1 = adv[1];
  assign en.s2 = adv[2];
  assign en.s3 = adv[3];
  assign en.s4 = adv[4];

  cdbd_day_number u_current (
    .clk    (clk),
    .en     (en),
    .year   (cy),
    .month  (cm),
    .day    (cd),
    .result (cur)
  );

  cdbd_day_number u_target (
    .clk    (clk),
    .en     (en),
    .year   (ty),
    .month  (tm),
    .day    (td),
    .result (tgt)
  );

  // difference and class
  logic        both_ok;
  logic [22:0] diff;
  logic [22:0] days_next;
  logic [1:0]  class_next;

  assign both_ok   = cur.ok && tgt.ok;
  assign diff      = tgt.num - cur.num;
  assign days_next = both_ok ? diff : 23'd0;

  always_comb begin
    if (days_next[22]) begin
      class_next = CLASS_EXPIRED;
    end else if (days_next == 23'd0) begin
      class_next = CLASS_DUE;
    end else begin
      class_next = CLASS_ACTIVE;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      days_between    <= days_next;
      dates_valid     <= both_ok;
      countdown_class <= class_next;
    end
  end

  `CDBD_ASSERT_IMPL(a_invalid_days, result_valid && !dates_valid, days_between == 23'sd0)
  `CDBD_ASSERT_IMPL(a_invalid_due, result_valid && !dates_valid, countdown_class == CLASS_DUE)
  `CDBD_ASSERT_NEXT(a_accept_fills, date_valid && !date_stall, vld[0])
  `CDBD_ASSERT_IMPL(a_stall_full, date_stall, vld == 6'h3f)
  `CDBD_ASSERT_IMPL(a_class_code, result_valid, countdown_class != 2'd3)

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb - days between dates core testbench
// Drives current/target date pairs through the valid/stall input channel and
// checks every result against an in-bench calendar predictor: validation,
// day numbers from 1970-01-01, signed difference and countdown class. Both
// channels idle at random, and the result side holds off once for a long
// stretch so that the pipeline fills and stalls its input.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cdbd_pkg::*;

  typedef struct {
    logic [13:0] cur_y;
    logic [3:0]  cur_m;
    logic [4:0]  cur_d;
    logic [13:0] tgt_y;
    logic [3:0]  tgt_m;
    logic [4:0]  tgt_d;
  } date_pair_t;

  typedef struct {
    logic signed [22:0] days;
    logic               ok;
    logic [1:0]         cls;
  } span_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               date_valid = 1'b0;
  logic               date_stall;
  logic [13:0]        current_year = '0;
  logic [3:0]         current_month = '0;
  logic [4:0]         current_day = '0;
  logic [13:0]        target_year = '0;
  logic [3:0]         target_month = '0;
  logic [4:0]         target_day = '0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic signed [22:0] days_between;
  logic               dates_valid;
  logic [1:0]         countdown_class;

  date_pair_t pair_q[$];
  span_t      span_q[$];
  int         err_cnt = 0;
  int         gap_cnt = 0;
  int         hold_cnt = 0;
  int         n_launch = 0;
  int         n_taken = 0;

  calendar_days_between_dates_core i_dut (
    .clk             (clk),
    .rst             (rst),
    .date_valid      (date_valid),
    .date_stall      (date_stall),
    .current_year    (current_year),
    .current_month   (current_month),
    .current_day     (current_day),
    .target_year     (target_year),
    .target_month    (target_month),
    .target_day      (target_day),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .days_between    (days_between),
    .dates_valid     (dates_valid),
    .countdown_class (countdown_class)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic bit is_leap(int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // 0 for an out-of-range month
  function automatic int month_days(int y, int m);
    int len_tab[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    if (m < 1 || m > 12) return 0;
    if (m == 2 && is_leap(y)) return 29;
    return len_tab[m - 1];
  endfunction

  function automatic bit date_ok(int y, int m, int d);
    if (y < 1970 || y > 9999 || d < 1) return 1'b0;
    return d <= month_days(y, m);
  endfunction

  // era-based day count, march-first years
  function automatic int epoch_days(int y, int m, int d);
    int yy;
    int era;
    int yoe;
    int mp;
    int doy;
    int doe;
    yy  = (m <= 2) ? y - 1 : y;
    era = yy / 400;
    yoe = yy - era * 400;
    mp  = (m > 2) ? m - 3 : m + 9;
    doy = (153 * mp + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe - 719468;
  endfunction

  function automatic span_t span_of(date_pair_t p);
    span_t s;
    int    diff;
    s.ok = date_ok(int'(p.cur_y), int'(p.cur_m), int'(p.cur_d)) &&
           date_ok(int'(p.tgt_y), int'(p.tgt_m), int'(p.tgt_d));
    diff = 0;
    if (s.ok) diff = epoch_days(int'(p.tgt_y), int'(p.tgt_m), int'(p.tgt_d)) -
                     epoch_days(int'(p.cur_y), int'(p.cur_m), int'(p.cur_d));
    s.days = diff[22:0];
    if (diff < 0) s.cls = CLASS_EXPIRED;
    else if (diff == 0) s.cls = CLASS_DUE;
    else s.cls = CLASS_ACTIVE;
    return s;
  endfunction

  // every third stretch of 150 transfers runs without idling
  function automatic int idle_draw(int n);
    if ((n / 150) % 3 == 2 || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 14);
  endfunction

  function automatic void pick_date(output logic [13:0] y, output logic [3:0] m,
                                    output logic [4:0] d);
    int len;
    case ($urandom_range(0, 9))
      0: y = 14'($urandom_range(1970, 1975));
      1: y = 14'($urandom_range(9995, 9999));
      2: y = 14'(4 * $urandom_range(493, 2499));
      default: y = 14'($urandom_range(1970, 9999));
    endcase
    m = 4'($urandom_range(1, 12));
    len = month_days(int'(y), int'(m));
    d = 5'(($urandom_range(0, 4) == 0) ? len : $urandom_range(1, len));
  endfunction

  function automatic void spoil_date(inout logic [13:0] y, inout logic [3:0] m,
                                     inout logic [4:0] d);
    int len;
    len = month_days(int'(y), int'(m));
    case ($urandom_range(0, 4))
      0: y = 14'($urandom_range(0, 1969));
      1: y = 14'($urandom_range(10000, 16383));
      2: m = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(13, 15));
      3: d = 5'd0;
      default: begin
        if (len < 31) d = 5'($urandom_range(len + 1, 31));
        else m = 4'($urandom_range(13, 15));
      end
    endcase
  endfunction

  task automatic add_pair(int cy, int cm, int cd, int ty, int tm, int td);
    date_pair_t p;
    p.cur_y = 14'(cy);
    p.cur_m = 4'(cm);
    p.cur_d = 5'(cd);
    p.tgt_y = 14'(ty);
    p.tgt_m = 4'(tm);
    p.tgt_d = 5'(td);
    pair_q.push_back(p);
  endtask

  // sender
  always @(posedge clk) begin
    date_pair_t nxt;
    int         gap;
    if (rst) begin
      date_valid <= 1'b0;
      gap_cnt <= 0;
    end else if (!date_valid || !date_stall) begin
      gap = date_valid ? idle_draw(n_launch) : gap_cnt;
      if (gap == 0 && pair_q.size() > 0) begin
        nxt = pair_q.pop_front();
        current_year  <= nxt.cur_y;
        current_month <= nxt.cur_m;
        current_day   <= nxt.cur_d;
        target_year   <= nxt.tgt_y;
        target_month  <= nxt.tgt_m;
        target_day    <= nxt.tgt_d;
        date_valid    <= 1'b1;
        gap_cnt       <= 0;
        n_launch++;
      end else begin
        date_valid <= 1'b0;
        gap_cnt <= (gap > 0) ? gap - 1 : 0;
      end
    end
  end

  // receiver, with one long hold-off to back the pipeline up
  always @(posedge clk) begin
    int hold;
    if (rst) begin
      result_stall <= 1'b0;
      hold_cnt <= 0;
    end else begin
      hold = hold_cnt;
      if (result_valid && !result_stall) begin
        n_taken++;
        hold = (n_taken == 400) ? 300 : idle_draw(n_taken);
      end else if (hold > 0) begin
        hold--;
      end
      hold_cnt <= hold;
      result_stall <= (hold > 0);
    end
  end

  // monitor: expectations queued on input transfers, checked on result transfers
  always @(posedge clk) begin
    date_pair_t seen;
    span_t      want;
    if (!rst) begin
      if (date_valid && !date_stall) begin
        seen.cur_y = current_year;
        seen.cur_m = current_month;
        seen.cur_d = current_day;
        seen.tgt_y = target_year;
        seen.tgt_m = target_month;
        seen.tgt_d = target_day;
        span_q.push_back(span_of(seen));
      end
      if (result_valid && !result_stall) begin
        if (span_q.size() == 0) begin
          $error("result transfer with nothing expected");
          err_cnt++;
        end else begin
          want = span_q.pop_front();
          if (days_between !== want.days) begin
            $error("days_between: expected %0d, got %0d", want.days, days_between);
            err_cnt++;
          end
          if (dates_valid !== want.ok) begin
            $error("dates_valid: expected %0d, got %0d", want.ok, dates_valid);
            err_cnt++;
          end
          if (countdown_class !== want.cls) begin
            $error("countdown_class: expected %0d, got %0d", want.cls, countdown_class);
            err_cnt++;
          end
        end
      end
    end
  end

  initial begin
    date_pair_t p;
    int         kind;

    add_pair(1970, 1, 1, 1970, 1, 1);
    add_pair(1970, 1, 1, 9999, 12, 31);
    add_pair(9999, 12, 31, 1970, 1, 1);
    add_pair(2000, 2, 29, 2000, 3, 1);
    add_pair(2100, 2, 29, 2100, 3, 1);
    add_pair(2024, 2, 29, 2023, 2, 28);
    add_pair(2023, 2, 29, 2023, 3, 1);
    add_pair(1969, 12, 31, 1970, 1, 1);
    add_pair(1970, 1, 1, 10000, 1, 1);
    add_pair(16383, 15, 31, 0, 0, 0);
    add_pair(0, 0, 0, 16383, 15, 31);
    add_pair(2020, 0, 10, 2020, 1, 10);
    add_pair(2020, 13, 10, 2020, 1, 10);
    add_pair(2020, 5, 0, 2020, 5, 1);
    add_pair(2021, 4, 31, 2021, 5, 1);
    add_pair(2021, 1, 31, 2021, 12, 31);
    add_pair(2020, 12, 31, 2021, 1, 1);
    add_pair(2400, 2, 29, 2399, 3, 1);
    add_pair(1972, 2, 29, 1972, 2, 28);
    add_pair(9999, 2, 29, 9996, 2, 29);
    add_pair(2020, 6, 30, 2020, 6, 31);
    add_pair(1999, 12, 31, 2000, 2, 29);

    repeat (1430) begin
      kind = $urandom_range(0, 99);
      pick_date(p.cur_y, p.cur_m, p.cur_d);
      pick_date(p.tgt_y, p.tgt_m, p.tgt_d);
      if (kind >= 60 && kind < 70) begin
        p.tgt_y = p.cur_y;
        p.tgt_m = p.cur_m;
        p.tgt_d = p.cur_d;
      end else if (kind >= 70 && kind < 80) begin
        p.tgt_y = p.cur_y;
      end else if (kind >= 80 && kind < 90) begin
        if ($urandom_range(0, 1)) spoil_date(p.cur_y, p.cur_m, p.cur_d);
        else spoil_date(p.tgt_y, p.tgt_m, p.tgt_d);
      end else if (kind >= 90) begin
        p.cur_y = 14'($urandom_range(0, 16383));
        p.cur_m = 4'($urandom_range(0, 15));
        p.cur_d = 5'($urandom_range(0, 31));
        p.tgt_y = 14'($urandom_range(0, 16383));
        p.tgt_m = 4'($urandom_range(0, 15));
        p.tgt_d = 5'($urandom_range(0, 31));
      end
      pair_q.push_back(p);
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (pair_q.size() > 0 || date_valid) @(posedge clk);
    while (span_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (err_cnt == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
